// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define NAE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// cond must never be true outside reset
`define NAE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define NAE_ASSERT(lbl, clk, rst_n, prop)
`define NAE_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hdl/nae_pkg.sv =====
// ----------------------------------------------------------------------------
// nae_pkg
// Types, constants and helper functions of the next alarm event scheduler.
// ----------------------------------------------------------------------------
package nae_pkg;

    localparam logic       ACT_WRITE        = 1'b0;
    localparam logic       ACT_TICK         = 1'b1;

    // paddr bit 2 selects the register
    localparam logic       REG_EVENT_COUNT  = 1'b0;
    localparam logic       REG_HOLD_TICKS   = 1'b1;

    localparam logic [7:0] HOLD_TICKS_RESET = 8'd5;
    localparam int         RTC_PM_BIT       = 5;
    localparam int         RTC_HOUR_TEN_BIT = 4;
    localparam int         HOURS_PER_HALF   = 12;

    typedef struct packed {
        logic       action;
        logic [3:0] entry_index;
        logic [6:0] event_hour;
        logic [6:0] event_minute;
        logic       event_pm;
        logic [7:0] rtc_hour_reg;
        logic [7:0] rtc_minute_reg;
    } item_t;

    typedef struct packed {
        logic       alarm_on;
        logic [3:0] next_index;
        logic [6:0] next_hour;
        logic [6:0] next_minute;
        logic       next_pm;
        logic       no_events;
    } result_t;

    typedef struct packed {
        logic [6:0] hour;
        logic [6:0] minute;
        logic       pm;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // hour mod 12 for a 7-bit value: reciprocal multiply, then one correction
    function automatic logic [3:0] hour_mod12(input logic [6:0] h);
        logic [13:0] p;
        logic [3:0]  q;
        logic [7:0]  r;
        p = 14'(h) * 14'd43;
        q = p[12:9];
        r = 8'(h) - 8'(q) * 8'(HOURS_PER_HALF);
        if (r >= 8'(HOURS_PER_HALF))
            r = r - 8'(HOURS_PER_HALF);
        return r[3:0];
    endfunction

    // ordering key: half of day, then hour mod 12, then minute
    function automatic logic [11:0] order_key(input logic pm, input logic [6:0] hour,
                                              input logic [6:0] minute);
        return {pm, hour_mod12(hour), minute};
    endfunction

    function automatic logic [6:0] rtc_hour(input logic [7:0] r);
        return (r[RTC_HOUR_TEN_BIT] ? 7'd10 : 7'd0) + 7'(r[3:0]);
    endfunction

    function automatic logic [6:0] rtc_minute(input logic [7:0] r);
        return 7'(r[6:4]) * 7'd10 + 7'(r[3:0]);
    endfunction

endpackage

// ===== hdl/next_alarm_event_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// next_alarm_event_scheduler_core
// Alarm event table with a sequential scan for the next upcoming event.
//
//   channel   dir  handshake                     payload
//   item      in   item_valid / item_stall       nae_pkg::item_t
//   result    out  result_valid / result_stall   nae_pkg::result_t
//   config    in   APB psel/penable/pwrite       event_count, alarm_hold_ticks
//
// A write item, or a tick on an empty table, goes from ST_IDLE through ST_FIN to its result.
// A tick with n = min(event_count, MAX_EVENTS) reads the table RAM one entry a
// cycle through its single read port and stops at the first hit, or after
// entry n-1 when none hits, then passes ST_EVAL and ST_FIN to its result.
// Reset clears control state; the table is undefined until written.
// A new item is taken while the previous result waits in the output register;
// a stalled result then holds the next one in ST_FIN and the item side stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module next_alarm_event_scheduler_core #(
    parameter int MAX_EVENTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  nae_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output nae_pkg::result_t  result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CW = $clog2(MAX_EVENTS + 1);
    localparam int ENTRY_BITS = nae_pkg::ENTRY_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;

    logic [2:0]             state_reg, state_next;
    logic [4:0]             event_count_reg;
    logic [7:0]             hold_ticks_reg;
    logic                   alarm_active_reg, alarm_active_next;
    logic [7:0]             hold_cnt_reg, hold_cnt_next;
    logic [CW-1:0]          n_reg, n_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          chk_idx_reg, chk_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [CW-1:0]          sel_idx_reg, sel_idx_next;
    nae_pkg::entry_t        sel_data_reg, sel_data_next;
    logic [11:0]            now_key_reg, now_key_next;
    logic [6:0]             c_hr_reg, c_hr_next;
    logic [6:0]             c_mn_reg, c_mn_next;
    logic                   c_ap_reg, c_ap_next;
    nae_pkg::result_t       res_reg, res_next;
    logic                   result_valid_reg, result_valid_next;
    nae_pkg::result_t       result_reg, result_next;

    logic                   item_xfer;
    logic                   cfg_wr;
    logic                   out_free;
    logic [CW-1:0]          n_cfg;
    logic                   ram_we;
    nae_pkg::entry_t        ram_wdata;
    logic [ENTRY_BITS-1:0]  ram_rdata;
    nae_pkg::entry_t        rd_entry;
    logic                   issue;
    logic                   hit;
    logic                   last;
    logic                   match;
    logic [7:0]             hold_inc;
    logic [6:0]             dec_hr;

    assign item_stall   = (state_reg != ST_IDLE);
    assign item_xfer    = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        unique case (paddr[2])
            nae_pkg::REG_EVENT_COUNT: prdata = {27'd0, event_count_reg};
            nae_pkg::REG_HOLD_TICKS:  prdata = {24'd0, hold_ticks_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_count_reg <= 5'd0;
            hold_ticks_reg  <= nae_pkg::HOLD_TICKS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                nae_pkg::REG_EVENT_COUNT: event_count_reg <= pwdata[4:0];
                nae_pkg::REG_HOLD_TICKS:  hold_ticks_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign n_cfg = (32'(event_count_reg) > MAX_EVENTS) ? CW'(MAX_EVENTS)
                                                       : CW'(event_count_reg);

    // event table
    assign ram_we    = item_xfer && (item.action == nae_pkg::ACT_WRITE)
                       && (32'(item.entry_index) < MAX_EVENTS);
    assign ram_wdata = '{hour: item.event_hour, minute: item.event_minute,
                         pm: item.event_pm};

    nae_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_EVENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(item.entry_index)),
        .wdata (ram_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry = nae_pkg::entry_t'(ram_rdata);
    assign issue    = (state_reg == ST_SCAN) && (cnt_reg < n_reg);
    assign hit      = nae_pkg::order_key(rd_entry.pm, rd_entry.hour, rd_entry.minute)
                      >= now_key_reg;
    assign last     = (chk_idx_reg + CW'(1)) == n_reg;
    assign match    = (sel_data_reg.hour == c_hr_reg) && (sel_data_reg.minute == c_mn_reg)
                      && (sel_data_reg.pm == c_ap_reg);
    assign hold_inc = hold_cnt_reg + 8'd1;
    assign dec_hr   = nae_pkg::rtc_hour(item.rtc_hour_reg);

    always_comb
    begin
        state_next        = state_reg;
        alarm_active_next = alarm_active_reg;
        hold_cnt_next     = hold_cnt_reg;
        n_next            = n_reg;
        cnt_next          = cnt_reg;
        chk_idx_next      = cnt_reg;
        chk_vld_next      = issue;
        sel_idx_next      = sel_idx_reg;
        sel_data_next     = sel_data_reg;
        now_key_next      = now_key_reg;
        c_hr_next         = c_hr_reg;
        c_mn_next         = c_mn_reg;
        c_ap_next         = c_ap_reg;
        res_next          = res_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    res_next           = '0;
                    res_next.no_events = (event_count_reg == 5'd0);
                    if (item.action == nae_pkg::ACT_WRITE)
                    begin
                        res_next.alarm_on = alarm_active_reg;
                        state_next        = ST_FIN;
                    end
                    else if (n_cfg == '0)
                    begin
                        // empty table forces the alarm off
                        alarm_active_next = 1'b0;
                        hold_cnt_next     = 8'd0;
                        state_next        = ST_FIN;
                    end
                    else
                    begin
                        c_hr_next    = dec_hr;
                        c_mn_next    = nae_pkg::rtc_minute(item.rtc_minute_reg);
                        c_ap_next    = item.rtc_hour_reg[nae_pkg::RTC_PM_BIT];
                        now_key_next = nae_pkg::order_key(c_ap_next, c_hr_next, c_mn_next);
                        n_next       = n_cfg;
                        cnt_next     = '0;
                        sel_idx_next = '0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                    cnt_next = cnt_reg + CW'(1);
                if (chk_vld_reg)
                begin
                    // entry 0 is kept as the fallback when no entry is at or after now
                    if (chk_idx_reg == '0 || hit)
                        sel_data_next = rd_entry;
                    if (hit)
                        sel_idx_next = chk_idx_reg;
                    if (hit || last)
                    begin
                        chk_vld_next = 1'b0;
                        state_next   = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                res_next.next_index  = 4'(sel_idx_reg);
                res_next.next_hour   = sel_data_reg.hour;
                res_next.next_minute = sel_data_reg.minute;
                res_next.next_pm     = sel_data_reg.pm;
                if (match)
                begin
                    alarm_active_next = 1'b1;
                    hold_cnt_next     = 8'd0;
                    res_next.alarm_on = 1'b1;
                end
                else if (alarm_active_reg)
                begin
                    if (hold_inc >= hold_ticks_reg)
                    begin
                        alarm_active_next = 1'b0;
                        hold_cnt_next     = 8'd0;
                        res_next.alarm_on = 1'b0;
                    end
                    else
                    begin
                        hold_cnt_next     = hold_inc;
                        res_next.alarm_on = 1'b1;
                    end
                end
                else
                    res_next.alarm_on = 1'b0;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next       = res_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            alarm_active_reg <= 1'b0;
            hold_cnt_reg     <= 8'd0;
            cnt_reg          <= '0;
            chk_vld_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            alarm_active_reg <= alarm_active_next;
            hold_cnt_reg     <= hold_cnt_next;
            cnt_reg          <= cnt_next;
            chk_vld_reg      <= chk_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        chk_idx_reg  <= chk_idx_next;
        sel_idx_reg  <= sel_idx_next;
        sel_data_reg <= sel_data_next;
        now_key_reg  <= now_key_next;
        c_hr_reg     <= c_hr_next;
        c_mn_reg     <= c_mn_next;
        c_ap_reg     <= c_ap_next;
        res_reg      <= res_next;
        result_reg   <= result_next;
    end

    `NAE_ASSERT(a_fin_loads_out, clk, rst_n,
        (state_reg == ST_FIN && out_free) |=> (result_valid_reg && state_reg == ST_IDLE))
    `NAE_ASSERT(a_chk_in_range, clk, rst_n, chk_vld_reg |-> (chk_idx_reg < n_reg))
    `NAE_ASSERT(a_hold_cleared, clk, rst_n, !alarm_active_reg |-> (hold_cnt_reg == 8'd0))
    `NAE_ASSERT_NEVER(a_scan_empty, clk, rst_n, (state_reg == ST_SCAN) && (n_reg == '0))

endmodule

// ===== hdl/nae_ram.sv =====
// ----------------------------------------------------------------------------
// nae_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module nae_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/sv/next_alarm_event_scheduler_checker.sv =====
// ----------------------------------------------------------------------------
// next_alarm_event_scheduler_checker
// Watches the item, result and register ports of the scheduler core, keeps
// its own copy of the event table and alarm state, predicts one result per
// accepted item and compares every accepted result with the oldest one.
// ----------------------------------------------------------------------------
module next_alarm_event_scheduler_checker #(
    parameter int SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  nae_pkg::item_t    item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  nae_pkg::result_t  result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                mismatches,
    output int                pending,
    output int                ticks_seen,
    output int                alarm_reports
);
    import nae_pkg::*;

    entry_t     slots [SLOTS];
    logic [4:0] event_count_q;
    logic [7:0] hold_limit;
    logic       alarm_lit;
    logic [7:0] hold_run;
    result_t    expected_reports [$];
    int         fail_total;
    int         tick_total;
    int         lit_total;

    // half of day first, then hour mod 12, then minute
    function automatic int unsigned time_rank(input logic pm, input logic [6:0] hr,
                                              input logic [6:0] mn);
        return (int'(pm) << 16) | ((int'(hr) % 12) << 8) | int'(mn);
    endfunction

    function automatic result_t advance_schedule(input item_t it);
        result_t     r;
        logic [6:0]  now_hr;
        logic [6:0]  now_mn;
        logic        now_pm;
        int unsigned now_rank;
        int          span;
        int          pick;
        r = '0;
        r.no_events = (event_count_q == 5'd0);
        if (it.action == ACT_WRITE)
        begin
            if (int'(it.entry_index) < SLOTS)
            begin
                slots[it.entry_index].hour   = it.event_hour;
                slots[it.entry_index].minute = it.event_minute;
                slots[it.entry_index].pm     = it.event_pm;
            end
            r.alarm_on = alarm_lit;
            return r;
        end
        now_hr = 7'(it.rtc_hour_reg[4]) * 7'd10 + 7'(it.rtc_hour_reg[3:0]);
        now_mn = 7'(it.rtc_minute_reg[6:4]) * 7'd10 + 7'(it.rtc_minute_reg[3:0]);
        now_pm = it.rtc_hour_reg[5];
        span   = (int'(event_count_q) > SLOTS) ? SLOTS : int'(event_count_q);
        if (span == 0)
        begin
            alarm_lit = 1'b0;
            hold_run  = 8'd0;
            r.no_events = 1'b1;
            return r;
        end
        // first slot not earlier than now; slot 0 when every slot is earlier
        now_rank = time_rank(now_pm, now_hr, now_mn);
        pick = 0;
        for (int i = 0; i < span; i++)
        begin
            if (time_rank(slots[i].pm, slots[i].hour, slots[i].minute) >= now_rank)
            begin
                pick = i;
                break;
            end
        end
        if (slots[pick].hour == now_hr && slots[pick].minute == now_mn &&
            slots[pick].pm == now_pm)
        begin
            alarm_lit = 1'b1;
            hold_run  = 8'd0;
        end
        else if (alarm_lit)
        begin
            hold_run = hold_run + 8'd1;
            if (hold_run >= hold_limit)
            begin
                alarm_lit = 1'b0;
                hold_run  = 8'd0;
            end
        end
        r.alarm_on    = alarm_lit;
        r.next_index  = 4'(pick);
        r.next_hour   = slots[pick].hour;
        r.next_minute = slots[pick].minute;
        r.next_pm     = slots[pick].pm;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input result_t want, input result_t got);
        fail_total++;
        if (fail_total <= 10)
        begin
            $display("%0t %s: expected on=%0d idx=%0d %0d:%0d pm=%0d empty=%0d",
                     $realtime, what, want.alarm_on, want.next_index, want.next_hour,
                     want.next_minute, want.next_pm, want.no_events);
            $display("    got on=%0d idx=%0d %0d:%0d pm=%0d empty=%0d",
                     got.alarm_on, got.next_index, got.next_hour, got.next_minute,
                     got.next_pm, got.no_events);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            foreach (slots[i])
                slots[i] = '0;
            event_count_q = 5'd0;
            hold_limit    = HOLD_TICKS_RESET;
            alarm_lit     = 1'b0;
            hold_run      = 8'd0;
            expected_reports.delete();
            fail_total    = 0;
            tick_total    = 0;
            lit_total     = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_EVENT_COUNT)
                    event_count_q = pwdata[4:0];
                else
                    hold_limit = pwdata[7:0];
            end
            // results first, so a transfer is never matched with its own item
            if (result_valid && !result_stall)
            begin
                if (result.alarm_on)
                    lit_total++;
                if (expected_reports.size() == 0)
                begin
                    note_mismatch("result with nothing outstanding", '0, result);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (result.alarm_on !== want.alarm_on ||
                        result.next_index !== want.next_index ||
                        result.next_hour !== want.next_hour ||
                        result.next_minute !== want.next_minute ||
                        result.next_pm !== want.next_pm ||
                        result.no_events !== want.no_events)
                        note_mismatch("result mismatch", want, result);
                end
            end
            if (item_valid && !item_stall)
            begin
                if (item.action == ACT_TICK)
                    tick_total++;
                expected_reports.push_back(advance_schedule(item));
            end
        end
        mismatches    <= fail_total;
        pending       <= expected_reports.size();
        ticks_seen    <= tick_total;
        alarm_reports <= lit_total;
    end

endmodule

// ===== tb/sv/next_alarm_event_scheduler_core_tb.sv =====
// ----------------------------------------------------------------------------
// next_alarm_event_scheduler_core_tb
// Drives table writes and clock ticks into the scheduler core with random
// gaps and output stalls, reprograms the event count and hold time between
// phases, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module next_alarm_event_scheduler_core_tb;
    import nae_pkg::*;

    localparam int SLOTS           = 16;
    localparam int DAY_MINUTES     = 1440;
    localparam int HALF_DAY        = 720;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 24;
    localparam int CYCLE_LIMIT     = 500000;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int ticks_seen;
    int alarm_reports;

    int cycle_count   = 0;
    int items_sent    = 0;
    int reg_writes    = 0;
    int clock_tod     = 0;
    int dwell         = 0;
    int span          = 0;
    int slot_tod [SLOTS];
    bit tx_steady     = 1'b0;
    int hold_off_reqs = 0;

    next_alarm_event_scheduler_core #(.MAX_EVENTS(SLOTS)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    next_alarm_event_scheduler_checker #(.SLOTS(SLOTS)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .pending       (pending),
        .ticks_seen    (ticks_seen),
        .alarm_reports (alarm_reports)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     CYCLE_LIMIT, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: quiet stretches, short random stalls, an occasional long one,
    // and one long hold-off on request
    initial
    begin : rx_side
        int hold_left;
        int stall_left;
        int stretch;
        int hold_seen;
        bit quiet;
        hold_left  = 0;
        stall_left = 0;
        stretch    = 0;
        hold_seen  = 0;
        quiet      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_reqs != hold_seen)
            begin
                hold_seen = hold_off_reqs;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (stretch == 0)
                begin
                    quiet   = ($urandom_range(0, 99) < 30);
                    stretch = $urandom_range(20, 150);
                end
                stretch--;
                if (quiet)
                begin
                    result_stall <= 1'b0;
                end
                else if ($urandom_range(0, 99) < 3)
                begin
                    stall_left = $urandom_range(10, 60);
                    result_stall <= 1'b1;
                end
                else
                begin
                    result_stall <= ($urandom_range(0, 99) < 30);
                end
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        if (tx_steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.action         = 1'($urandom_range(0, 1));
        it.entry_index    = 4'($urandom_range(0, SLOTS - 1));
        it.event_hour     = 7'($urandom_range(0, 99));
        it.event_minute   = 7'($urandom_range(0, 99));
        it.event_pm       = 1'($urandom_range(0, 1));
        it.rtc_hour_reg   = 8'($urandom_range(0, 255));
        it.rtc_minute_reg = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic item_t raw_tick(input logic [7:0] hour_reg, input logic [7:0] minute_reg);
        item_t it;
        it = noise_item();
        it.action         = ACT_TICK;
        it.rtc_hour_reg   = hour_reg;
        it.rtc_minute_reg = minute_reg;
        return it;
    endfunction

    // encode a time of day as RTC bytes; unused high bits carry noise
    function automatic item_t tick_at(input int tod);
        int   hr;
        logic pm;
        pm = (tod >= HALF_DAY);
        hr = (tod % HALF_DAY) / 60;
        if (hr == 0)
            hr = 12;
        return raw_tick({2'($urandom), pm, 1'(hr >= 10), 4'(hr % 10)},
                        {1'($urandom), 3'((tod % 60) / 10), 4'(tod % 10)});
    endfunction

    function automatic item_t write_item(input int slot, input int hr, input int mn,
                                         input logic pm);
        item_t it;
        it = noise_item();
        it.action       = ACT_WRITE;
        it.entry_index  = 4'(slot);
        it.event_hour   = 7'(hr);
        it.event_minute = 7'(mn);
        it.event_pm     = pm;
        return it;
    endfunction

    function automatic item_t entry_at(input int slot, input int tod);
        int hr;
        hr = (tod % HALF_DAY) / 60;
        if (hr == 0)
            hr = 12;
        slot_tod[slot] = tod;
        return write_item(slot, hr, tod % 60, tod >= HALF_DAY);
    endfunction

    // mostly a running clock plus writes near it, some jumps onto stored
    // events, a little raw noise
    function automatic item_t next_random_item();
        item_t it;
        int    roll;
        int    slot;
        roll = $urandom_range(0, 99);
        slot = $urandom_range(0, SLOTS - 1);
        if (roll < 5)
        begin
            it = noise_item();
            if (it.action == ACT_WRITE)
                slot_tod[it.entry_index] = -1;
            return it;
        end
        if (roll < 9)
        begin
            slot_tod[slot] = -1;
            return write_item(slot, $urandom_range(0, 99), $urandom_range(0, 99),
                              1'($urandom_range(0, 1)));
        end
        if (roll < 22)
            return entry_at(slot, (clock_tod + $urandom_range(0, 8)) % DAY_MINUTES);
        if (roll < 32 && span > 0)
        begin
            slot = $urandom_range(0, span - 1);
            if (slot_tod[slot] >= 0)
            begin
                clock_tod = slot_tod[slot];
                dwell     = $urandom_range(1, 4);
            end
        end
        if (dwell == 0)
        begin
            clock_tod = (clock_tod + 1) % DAY_MINUTES;
            dwell     = $urandom_range(1, 4);
        end
        dwell--;
        return tick_at(clock_tod);
    endfunction

    task automatic offer_item(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        items_sent++;
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic program_reg(input logic sel, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic run_phase(input int count, input int hold, input int n_items,
                             input bit steady, input bit squeeze, input bit pauses);
        int k;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        program_reg(REG_EVENT_COUNT, count);
        program_reg(REG_HOLD_TICKS, hold);
        span      = (count > SLOTS) ? SLOTS : count;
        tx_steady = steady;
        if (squeeze)
            hold_off_reqs++;
        for (k = 0; k < n_items; k++)
        begin
            if (pauses && $urandom_range(0, 24) == 0)
                drain_results();
            offer_item(next_random_item());
        end
        tx_steady = 1'b0;
    endtask

    initial
    begin : stimulus
        int s;
        foreach (slot_tod[i])
            slot_tod[i] = -1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then a small ordered table
        offer_item(raw_tick(8'hFF, 8'hFF));
        offer_item(entry_at(0, 90));
        offer_item(entry_at(1, HALF_DAY));
        offer_item(entry_at(2, 1065));
        offer_item(entry_at(3, 1438));
        offer_item(write_item(15, 99, 99, 1'b1));
        offer_item(write_item(14, 0, 0, 1'b0));
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        program_reg(REG_EVENT_COUNT, 4);
        program_reg(REG_HOLD_TICKS, 2);
        offer_item(raw_tick(8'h01, 8'h29));
        offer_item(raw_tick(8'h01, 8'h30));     // equal to slot 0: alarm on
        offer_item(raw_tick(8'h01, 8'h30));
        offer_item(raw_tick(8'h01, 8'h31));     // hold count 1
        offer_item(raw_tick(8'h01, 8'h32));     // hold count reaches limit
        offer_item(raw_tick(8'h32, 8'h00));     // 12:00 PM
        offer_item(raw_tick(8'h31, 8'h59));     // later than every event
        offer_item(entry_at(3, 1438));          // write while alarm is on
        offer_item(raw_tick(8'h31, 8'h59));
        offer_item(raw_tick(8'hDF, 8'hFF));     // digits above nine
        offer_item(raw_tick(8'h00, 8'h00));
        offer_item(raw_tick(8'h12, 8'h00));     // 12 AM ranks as hour zero
        offer_item(raw_tick(8'hE5, 8'hC5));     // noise in high bits, 5:45 PM

        // fill the whole table before any scan can reach it
        for (s = 0; s < SLOTS; s++)
            offer_item(entry_at(s, $urandom_range(0, DAY_MINUTES - 1)));
        clock_tod = slot_tod[$urandom_range(0, SLOTS - 1)];

        run_phase(SLOTS, 1, 90, 1'b0, 1'b0, 1'b0);
        run_phase(1, 255, 80, 1'b1, 1'b0, 1'b0);
        run_phase(0, $urandom_range(1, 255), 40, 1'b0, 1'b0, 1'b0);
        run_phase(31, $urandom_range(2, 12), 80, 1'b0, 1'b1, 1'b0);
        run_phase($urandom_range(2, 15), 3, 80, 1'b0, 1'b0, 1'b1);
        run_phase($urandom_range(1, SLOTS), $urandom_range(1, 255), 80, 1'b0, 1'b0, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d items (%0d clock ticks, rest table writes);",
                 items_sent, ticks_seen);
        $display("%0d results had the alarm on; %0d register writes, counts empty to oversize.",
                 alarm_reports, reg_writes);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
